/* hdl/shp_pkg.sv */
// ----------------------------------------------------------------------------
// shp_pkg: shared types and constants of the 3x3 cross sharpening filter
// Word formats of both stream channels, configuration register indexes and
// the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package shp_pkg;

  localparam int unsigned PIXEL_W        = 8;
  localparam int unsigned FRAME_WIDTH_W  = 11;
  localparam int unsigned FRAME_HEIGHT_W = 12;
  localparam int unsigned CFG_DATA_W     = 12;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned MIN_DIM        = 3;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_in;
    logic               drain;
  } in_word_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               frame_last;
  } out_word_t;

endpackage

`default_nettype wire

/* hdl/shp_ram.sv */
// ----------------------------------------------------------------------------
// shp_ram: generic simple dual-port RAM
// One write port and one read port, registered read data. A read and a write
// to the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module shp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/sharpen_3x3_cross.sv */
// ----------------------------------------------------------------------------
// sharpen_3x3_cross: streaming 3x3 cross-kernel sharpening
// Raster-order 8-bit grayscale in, sharpened frame out, two line stores.
// ----------------------------------------------------------------------------
// The block takes one word per clock and keeps that rate for as long as the
// output side does not stall; output stalls back up through a three-word
// queue and then hold the input. Each word costs one read and one write on
// each of the two line-store RAMs, and
// those accesses are split over a two-stage read/modify/write pipeline, with
// a forwarding register covering the case where the same column is read right
// after it was written. The word that causes a result is registered in stage
// one, then the result enters the output queue; output pixel k is caused by
// input word k+W+1, with W the frame width. After the last pixel of a frame,
// send W+1 words with drain set to flush the remaining results; frame_last
// marks the final output pixel, after which the next word starts a new frame.
// A drain word that arrives while pixels are still expected is consumed and
// dropped. Interior outputs are 5*center minus the four cross neighbors,
// clamped to 0..255; the outer ring of the frame reads as 0. Widths below 3
// act as 3 and above MAX_WIDTH as MAX_WIDTH, heights below 3 as 3. The line
// stores need no clearing pass after reset: unwritten entries only ever feed
// border pixels. Write frame_width/frame_height only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sharpen_3x3_cross #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration write port
  input  wire logic                                   cfg_we_i,
  input  wire logic [shp_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [shp_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // input stream
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire shp_pkg::in_word_t                      in_word_i,
  // output stream
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output shp_pkg::out_word_t                          out_word_o
);

  import shp_pkg::*;

  // column address, effective width, row counter and output counter widths
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned RW = FRAME_HEIGHT_W + 1;
  localparam int unsigned PW = EW + FRAME_HEIGHT_W;

  localparam int unsigned RST_W_EFF =
      (int'(FRAME_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH : int'(FRAME_WIDTH_RST);
  localparam int unsigned RST_WHM1 = RST_W_EFF * int'(FRAME_HEIGHT_RST) - 1;

  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FP_W       = 2;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  function automatic logic [EW-1:0] clamp_width(input logic [FRAME_WIDTH_W-1:0] v);
    logic [EW-1:0] r;
    if (32'(v) < MIN_DIM) begin
      r = EW'(MIN_DIM);
    end else if (32'(v) > MAX_WIDTH) begin
      r = EW'(MAX_WIDTH);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  function automatic logic [FRAME_HEIGHT_W-1:0] clamp_height(
      input logic [FRAME_HEIGHT_W-1:0] v);
    logic [FRAME_HEIGHT_W-1:0] r;
    if (32'(v) < MIN_DIM) begin
      r = FRAME_HEIGHT_W'(MIN_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [FRAME_WIDTH_W-1:0]  width_q, width_d;
  logic [FRAME_HEIGHT_W-1:0] height_q, height_d;
  logic [PW-1:0]             whm1_q, whm1_d;   // frame pixel count minus one

  logic [EW-1:0]             eff_w;
  logic [FRAME_HEIGHT_W-1:0] eff_h;
  logic [EW-1:0]             mul_w;
  logic [FRAME_HEIGHT_W-1:0] mul_h;
  logic [PW-1:0]             mul_p;

  assign eff_w = clamp_width(width_q);
  assign eff_h = clamp_height(height_q);

  // Recompute the frame size at the write itself, so the very next word
  // already sees it.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    mul_w    = eff_w;
    mul_h    = eff_h;
    case (cfg_idx_i)
      REG_FRAME_WIDTH: begin
        width_d = cfg_data_i[FRAME_WIDTH_W-1:0];
        mul_w   = clamp_width(cfg_data_i[FRAME_WIDTH_W-1:0]);
      end
      REG_FRAME_HEIGHT: begin
        height_d = cfg_data_i[FRAME_HEIGHT_W-1:0];
        mul_h    = clamp_height(cfg_data_i[FRAME_HEIGHT_W-1:0]);
      end
      default: begin
      end
    endcase
    mul_p  = PW'(mul_w) * PW'(mul_h);
    whm1_d = mul_p - PW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      whm1_q   <= PW'(RST_WHM1);
    end else if (cfg_we_i) begin
      width_q  <= width_d;
      height_q <= height_d;
      whm1_q   <= whm1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: position counters, frame bookkeeping, line-store read
  // --------------------------------------------------------------------------
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] oc_q, oc_d;

  logic               in_fire;
  logic               row_live;   // frame pixels still expected
  logic               active;     // word updates the line stores
  logic [PIXEL_W-1:0] pix0;
  logic               emit0;
  logic               interior0;
  logic               last0;
  logic [CW-1:0]      col_inc;
  logic               col_wrap;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign row_live = row_q < RW'(eff_h);
  assign active   = in_fire && !(row_live && in_word_i.drain);
  // past the last row, every word feeds zeros, drain set or not
  assign pix0     = row_live ? in_word_i.pixel_in : '0;

  // the word at (row, col) completes the output at (row-1, col-1)
  assign emit0     = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
  assign interior0 = (col_q >= AW'(2)) && (CW'(col_q) < CW'(eff_w)) &&
                     (row_q >= RW'(2)) && row_live;
  assign last0     = oc_q >= whm1_q;

  assign col_inc  = CW'(col_q) + CW'(1);
  assign col_wrap = col_inc >= CW'(eff_w);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    oc_d  = oc_q;
    if (active) begin
      if (emit0 && last0) begin
        // frame done: start over
        col_d = '0;
        row_d = '0;
        oc_d  = '0;
      end else begin
        if (emit0) begin
          oc_d = oc_q + PW'(1);
        end
        if (col_wrap) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else begin
          col_d = col_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      oc_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      oc_q  <= oc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: window update, kernel, line-store write-back
  // --------------------------------------------------------------------------
  logic               s1_valid_q;
  logic               s1_emit_q;
  logic               s1_last_q;
  logic               s1_interior_q;
  logic [PIXEL_W-1:0] s1_pix_q;
  logic [AW-1:0]      s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active) begin
      s1_emit_q     <= emit0;
      s1_last_q     <= emit0 && last0;
      s1_interior_q <= interior0;
      s1_pix_q      <= pix0;
      s1_addr_q     <= col_q;
    end
  end

  logic [PIXEL_W-1:0] ram_two_rd, ram_one_rd;
  logic [PIXEL_W-1:0] row2_rd;   // pixel two rows above
  logic [PIXEL_W-1:0] row1_rd;   // pixel one row above

  // store one holds the row above, store two the row above that
  shp_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_one (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_pix_q),
    .re_i   (active),
    .raddr_i(col_q),
    .rdata_o(ram_one_rd)
  );

  shp_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_two (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_addr_q),
    .wdata_i(row1_rd),
    .re_i   (active),
    .raddr_i(col_q),
    .rdata_o(ram_two_rd)
  );

  // Forward the write-back when the next read hits the same column in the
  // same cycle (happens at a frame restart); the RAM returns stale data then.
  logic               fwd_q;
  logic [PIXEL_W-1:0] fwd_two_q, fwd_one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= active && s1_valid_q && (col_q == s1_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fwd_two_q <= row1_rd;
      fwd_one_q <= s1_pix_q;
    end
  end

  assign row2_rd = fwd_q ? fwd_two_q : ram_two_rd;
  assign row1_rd = fwd_q ? fwd_one_q : ram_one_rd;

  // Cross window: center and left from the row above, up from two rows
  // above and down from the incoming row, all one column back but left,
  // which is two back; right is the fresh row-one read.
  logic [PIXEL_W-1:0] win_left_q, win_ctr_q, win_up_q, win_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q <= '0;
      win_ctr_q  <= '0;
      win_up_q   <= '0;
      win_down_q <= '0;
    end else if (s1_valid_q) begin
      win_left_q <= win_ctr_q;
      win_ctr_q  <= row1_rd;
      win_up_q   <= row2_rd;
      win_down_q <= s1_pix_q;
    end
  end

  logic [PIXEL_W+2:0] pos_sum;   // 5 * center
  logic [PIXEL_W+1:0] neg_sum;   // sum of the four neighbors
  logic [PIXEL_W+2:0] diff;
  logic [PIXEL_W-1:0] sharp;

  always_comb begin
    pos_sum = (PIXEL_W+3)'({win_ctr_q, 2'b00}) + (PIXEL_W+3)'(win_ctr_q);
    neg_sum = (PIXEL_W+2)'(win_left_q) + (PIXEL_W+2)'(row1_rd) +
              (PIXEL_W+2)'(win_up_q) + (PIXEL_W+2)'(win_down_q);
    diff    = pos_sum - (PIXEL_W+3)'(neg_sum);
    if (!s1_interior_q || ((PIXEL_W+3)'(neg_sum) >= pos_sum)) begin
      sharp = '0;
    end else if (diff[PIXEL_W+2:PIXEL_W] != '0) begin
      sharp = '1;
    end else begin
      sharp = diff[PIXEL_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output queue: three words cover the credit loop at full rate
  // --------------------------------------------------------------------------
  out_word_t       fifo_q [FIFO_DEPTH];
  logic [FP_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FP_W-1:0] cnt_q;
  logic            push, pop;

  assign push = s1_valid_q && s1_emit_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{pixel_out: sharp, frame_last: s1_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == FP_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FP_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FP_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FP_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + FP_W'(1);
        2'b01:   cnt_q <= cnt_q - FP_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // hold input while the queue could not absorb one more result
  assign in_stall_o  = ((FP_W+1)'(cnt_q) + (FP_W+1)'(s1_valid_q)) >= (FP_W+1)'(FIFO_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_word_o  = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

/* hdl/shp_checker.sv */
// ----------------------------------------------------------------------------
// shp_checker: port-level checks of the sharpening filter
// Watches the stream handshakes of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module shp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire shp_pkg::out_word_t out_word_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // with nothing queued, the input is never held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output queue");

  // draining one result frees the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_valid_o && !out_stall_i |=> !in_stall_o)
    else $error("input still stalled after an output word left");

  // a rise of the output valid traces back to an accepted input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output word without a matching input word");

endmodule

bind sharpen_3x3_cross shp_checker u_shp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

`default_nettype wire

/* tb/sv/sharpen_3x3_cross_checker.sv */
// ----------------------------------------------------------------------------
// sharpen_3x3_cross_checker: prediction and comparison for the sharpen filter
// Watches the configuration port and both stream channels. Every accepted
// input word runs through a cycle-free model of the line stores and the cross
// window, and every accepted output word is compared with the oldest
// predicted pixel.
// ----------------------------------------------------------------------------
module sharpen_3x3_cross_checker #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [shp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [shp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  shp_pkg::in_word_t                   in_word_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  shp_pkg::out_word_t                  out_word_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  import shp_pkg::*;

  logic [FRAME_WIDTH_W-1:0]  width_reg;
  logic [FRAME_HEIGHT_W-1:0] height_reg;

  // rows one and two above the incoming pixel
  logic [PIXEL_W-1:0] row_near [MAX_WIDTH];
  logic [PIXEL_W-1:0] row_far  [MAX_WIDTH];

  logic [PIXEL_W-1:0] win_left, win_center, win_up, win_down, win_right;
  int unsigned        col_pos, row_pos, out_total;

  out_word_t          sharpened_q [$];

  task automatic sharpen_step(input in_word_t word);
    int unsigned  cols, rows, c, ro, co;
    logic [7:0]   p, up2, up1;
    int           level;
    logic         emit;
    out_word_t    res;
    cols = width_reg;
    if (cols < MIN_DIM) cols = MIN_DIM;
    if (cols > MAX_WIDTH) cols = MAX_WIDTH;
    rows = height_reg;
    if (rows < MIN_DIM) rows = MIN_DIM;
    p = word.pixel_in;

    // drain before the frame is complete: drop it; past the frame: flush zeros
    if (row_pos < rows) begin
      if (word.drain) return;
    end else begin
      p = '0;
    end
    c = (col_pos >= MAX_WIDTH) ? 0 : col_pos;

    up2 = row_far[c];
    up1 = row_near[c];
    row_far[c]  = up1;
    row_near[c] = p;
    win_right   = up1;
    emit = (row_pos >= 2) || (row_pos == 1 && c >= 1);

    if (emit) begin
      if (c == 0) begin
        co = cols - 1;
        ro = row_pos - 2;
      end else begin
        co = c - 1;
        ro = row_pos - 1;
      end
      res.pixel_out = '0;
      if (!(ro == 0 || ro >= rows - 1 || co == 0 || co >= cols - 1)) begin
        level = 5 * int'(win_center) - int'(win_left) - int'(win_right)
              - int'(win_up) - int'(win_down);
        if (level < 0) level = 0;
        if (level > 255) level = 255;
        res.pixel_out = level[7:0];
      end
      res.frame_last = (out_total + 1 >= cols * rows);
      sharpened_q.push_back(res);
    end

    win_left   = win_center;
    win_center = win_right;
    win_up     = up2;
    win_down   = p;

    if (emit && res.frame_last) begin
      col_pos   = 0;
      row_pos   = 0;
      out_total = 0;
      return;
    end
    if (emit) out_total++;
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_near[i] = '0;
        row_far[i]  = '0;
      end
      {win_left, win_center, win_up, win_down, win_right} = '0;
      col_pos      = 0;
      row_pos      = 0;
      out_total    = 0;
      sharpened_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  width_reg  = cfg_data_i[FRAME_WIDTH_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data_i[FRAME_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) sharpen_step(in_word_i);
      if (out_valid_i && !out_stall_i) begin
        if (sharpened_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: output word with none expected: expected nothing, actual %0d/%0b",
                   $time, out_word_i.pixel_out, out_word_i.frame_last);
        end else begin
          want = sharpened_q.pop_front();
          if (out_word_i.pixel_out !== want.pixel_out) begin
            fail_count_o++;
            $display("%0t: pixel_out expected %0d, actual %0d",
                     $time, want.pixel_out, out_word_i.pixel_out);
          end
          if (out_word_i.frame_last !== want.frame_last) begin
            fail_count_o++;
            $display("%0t: frame_last expected %0b, actual %0b",
                     $time, want.frame_last, out_word_i.frame_last);
          end
        end
      end
      pending_o = sharpened_q.size();
    end
  end

endmodule

/* tb/sv/tb_sharpen_3x3_cross.sv */
// ----------------------------------------------------------------------------
// tb_sharpen_3x3_cross: stream test of the 3x3 cross sharpening filter
// Drives whole frames with their flush words through the block under random
// idling on both channels, over a range of small frame sizes starting at the
// clamped minimum. A checker beside the block predicts and compares every
// output word; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb_sharpen_3x3_cross;

  import shp_pkg::*;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned LIMIT     = 2_000_000; // cycles before the watchdog fires
  localparam int unsigned SETTLE    = 4;         // block latency plus margin
  localparam int unsigned RANDOM_WORDS = 600;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  cfg_reg_e  cfg_idx   = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int unsigned fail_count, pending, cycles = 0, fed = 0;
  bit          quiet = 1'b0; // set for the last part: no idling anywhere
  bit          calm  = 1'b0; // per-frame stretch with no sender gaps

  sharpen_3x3_cross #(
    .MAX_WIDTH (MAX_WIDTH)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  sharpen_3x3_cross_checker #(
    .MAX_WIDTH (MAX_WIDTH)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the stream hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver side: stall in random bursts, with long clean stretches in
  // between; stop stalling once the quiet part begins.
  initial begin : out_stall_gen
    int unsigned n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet) begin
        case ($urandom_range(0, 15))
          0, 1, 2: begin
            out_stall <= 1'b1;
            n = $urandom_range(1, 10);
            repeat (n) @(negedge clk);
            out_stall <= 1'b0;
          end
          3: repeat ($urandom_range(20, 200)) @(negedge clk);
          default: ;
        endcase
      end
    end
  end

  // Skew pixel values toward the extremes so both clamps fire often.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one word at a falling edge, maybe after an idle burst, and hold
  // it until the block takes it. Valid stays high on return so a following
  // word goes out back to back.
  task automatic send_word(input in_word_t word);
    int unsigned gap;
    if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted pixel has come out, then wait
  // out the SETTLE margin so the pipeline goes quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // One well-formed frame with random content: cols*rows pixels, then cols+1
  // flush words. Noise keeps alignment: a stray drain inside the frame is
  // dropped by the block, and a pixel in a flush slot acts as a drain.
  task automatic run_frame(input int unsigned cols, input int unsigned rows, input bit hold);
    int unsigned total, hold_at;
    in_word_t    word;
    total   = cols * rows;
    hold_at = $urandom_range(0, total - 1);
    calm    = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < total; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        word.pixel_in = 8'($urandom_range(0, 255));
        word.drain    = 1'b1;
        send_word(word);
      end
      if (hold && k == hold_at) settle();
      word.pixel_in = pick_pixel();
      word.drain    = 1'b0;
      send_word(word);
      fed++;
    end
    for (int unsigned j = 0; j <= cols; j++) begin
      word.pixel_in = 8'($urandom_range(0, 255));
      word.drain    = ($urandom_range(0, 9) != 0);
      send_word(word);
      fed++;
    end
    // extra drain between frames: ignored at the start of the next one
    if ($urandom_range(0, 7) == 0) begin
      word.pixel_in = 8'($urandom_range(0, 255));
      word.drain    = 1'b1;
      send_word(word);
    end
    calm = 1'b0;
  endtask

  // Reprogram the frame size while idle, then stream a few frames.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] wdata, input logic [CFG_DATA_W-1:0] hdata,
                           input int unsigned frames, input bit first_hold);
    int unsigned cols, rows;
    settle();
    cfg_write(REG_FRAME_WIDTH, wdata);
    cfg_write(REG_FRAME_HEIGHT, hdata);
    cols = wdata[FRAME_WIDTH_W-1:0];
    if (cols < MIN_DIM) cols = MIN_DIM;
    if (cols > MAX_WIDTH) cols = MAX_WIDTH;
    rows = hdata;
    if (rows < MIN_DIM) rows = MIN_DIM;
    for (int unsigned f = 0; f < frames; f++) begin
      run_frame(cols, rows, (f == 0 && first_hold) || $urandom_range(0, 3) == 0);
    end
  endtask

  // Directed 3x3 frames: only the center pixel is interior.
  // BRIGHT drives 5*255 against dark neighbors (clamp high), DARK drives a
  // black center against white neighbors (clamp low).
  localparam logic [71:0] BRIGHT = 72'hFF00FF_00FF00_FF00FF;
  localparam logic [71:0] DARK   = 72'h00FF00_FF00FF_00FF00;

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] wd, hd;
    int unsigned           waited;
    in_word_t              word;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part: smallest frame, both clamps, both kinds of noise ---
    cfg_write(REG_FRAME_WIDTH, 12'd3);
    cfg_write(REG_FRAME_HEIGHT, 12'd3);
    word = '{pixel_in: 8'hA5, drain: 1'b1}; // drain before any pixel: dropped
    send_word(word);
    for (int k = 0; k < 9; k++) begin
      word = '{pixel_in: BRIGHT[8*(8-k) +: 8], drain: 1'b0};
      send_word(word);
    end
    word = '{pixel_in: 8'h00, drain: 1'b1};
    send_word(word);
    word = '{pixel_in: 8'hFF, drain: 1'b0}; // pixel past frame end acts as drain
    send_word(word);
    word = '{pixel_in: 8'h5A, drain: 1'b1};
    send_word(word);
    send_word(word);
    for (int k = 0; k < 9; k++) begin
      word = '{pixel_in: DARK[8*(8-k) +: 8], drain: 1'b0};
      send_word(word);
    end
    word = '{pixel_in: 8'hFF, drain: 1'b1};
    repeat (4) send_word(word);

    // --- sizes below the minimum clamp to 3x3 ---
    run_phase(12'd0, 12'd0, 3, 1'b1);

    // --- random sizes, mostly small, sometimes below the minimum ---
    fed = 0;
    while (fed < RANDOM_WORDS) begin
      wd = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2))
                                       : 12'($urandom_range(3, 16));
      hd = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2))
                                       : 12'($urandom_range(3, 8));
      run_phase(wd, hd, $urandom_range(1, 2), 1'b0);
    end

    // --- last part: full rate, no idling on either side ---
    quiet = 1'b1;
    run_phase(12'($urandom_range(3, 16)), 12'($urandom_range(3, 8)), 2, 1'b0);

    // Wait out the remaining pixels and the pipeline tail, bounded.
    in_valid <= 1'b0;
    waited = 0;
    @(negedge clk);
    while (pending != 0 && waited < 50_000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4 * SETTLE) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
